FILE: sv/cosh_taylor_series_sum_defines.svh
// assertion macros for the hyperbolic cosine series block
`ifndef COSH_TAYLOR_SERIES_SUM_DEFINES_SVH
`define COSH_TAYLOR_SERIES_SUM_DEFINES_SVH

`ifndef SYNTH
// checked property, held off while reset is high
`define CTS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cosh series assertion failed");
// checked property, also checked during reset
`define CTS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("cosh series assertion failed");
`else
`define CTS_ASSERT(lbl, clk, rst, prop)
`define CTS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: sv/cts_pkg.sv
// shared types and constants for the hyperbolic cosine series block
`timescale 1ns / 1ps
`default_nettype none
package cts_pkg;

   localparam int X_W            = 17;
   localparam int THR_W          = 32;
   localparam int SUM_OUT_W      = 31;
   localparam int CNT_OUT_W      = 5;
   localparam int ONE_POS        = 30;
   localparam int MAX_TERMS_DEF  = 16;
   localparam int X_FRAC_DEF     = 16;

   localparam logic [THR_W-1:0]     THR_RESET = 32'd1073742;
   localparam logic [SUM_OUT_W-1:0] SUM_MAX   = 31'h7FFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL1,
      ST_MUL2,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic load_item;
      logic add_term;
      logic load_p1;
      logic div_start;
      logic load_term;
      logic load_rsp;
   } seq_ctl_type;

endpackage
`default_nettype wire

FILE: sv/cts_chan_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface cts_req_if;
   logic                   valid;
   logic                   ready;
   logic [cts_pkg::X_W-1:0] x_value;

   modport source (output valid, output x_value, input ready);
   modport sink   (input valid, input x_value, output ready);
endinterface

interface cts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cts_pkg::SUM_OUT_W-1:0] series_sum;
   logic [cts_pkg::CNT_OUT_W-1:0] term_count;

   modport source (output valid, output series_sum, output term_count, input ready);
   modport sink   (input valid, input series_sum, input term_count, output ready);
endinterface
`default_nettype wire

FILE: sv/cts_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module cts_div #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [NUM_W-1:0]      dividend,
   input  wire logic [DEN_W-1:0]      divisor,
   output cts_pkg::div_stat_type      stat,
   output logic [NUM_W-1:0]           quotient
);
   import cts_pkg::*;

   localparam int CW = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           ge;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         den_ff <= divisor;
      end
   end

   assign stat     = div_stat_type'{busy: busy_ff, done: done_ff};
   assign quotient = quo_ff;

endmodule
`default_nettype wire

FILE: sv/cosh_taylor_series_sum.sv
// top level: hyperbolic cosine by truncated taylor series, fixed point
`timescale 1ns / 1ps
`default_nettype none
`include "cosh_taylor_series_sum_defines.svh"
// Takes x_value (unsigned, X_FRAC_BITS fraction bits) on the req channel and returns
// cosh(x) in unsigned Q1.30 with the number of terms summed on the rsp channel.
// The series starts at 1.0 and adds a further term while the last one added is at
// least the threshold written on the csr port (reset 1073742, about 0.001), up to
// MAX_TERMS terms; the sum saturates at 2147483647. One item is worked at a time
// and req is not ready meanwhile. Each further term costs two passes through one
// shared multiplier and a bit-serial divide, the divider giving one quotient bit
// per cycle over its NUM_W-bit dividend. The result becomes valid in the same cycle
// that req is ready again; the last step holds while the output register is full
// and rsp is not ready. The result sits in an output register, so the next beat
// is taken while it waits.
module cosh_taylor_series_sum #(
   parameter int MAX_TERMS   = cts_pkg::MAX_TERMS_DEF,
   parameter int X_FRAC_BITS = cts_pkg::X_FRAC_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   cts_req_if.sink                     req_chan,
   cts_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_wr_en,
   input  wire logic [cts_pkg::THR_W-1:0] csr_wr_data
);
   import cts_pkg::*;

   // guard bits the integer part of x can add per multiply
   localparam int XG   = (X_W > X_FRAC_BITS) ? (X_W - X_FRAC_BITS) : 0;
   localparam int TW   = THR_W + 2 * XG;
   localparam int P1W  = TW + XG;
   localparam int P2W  = TW + 2 * XG;
   localparam int PRW  = P1W + X_W;
   localparam int NCW  = $clog2(MAX_TERMS + 1);
   localparam int DW   = 2 * (NCW + 1);
   localparam int SW   = TW + $clog2(MAX_TERMS + 1);

   state_type   state_ff, state_in;
   seq_ctl_type ctl;

   logic [THR_W-1:0] thr_ff;
   logic [X_W-1:0]   x_ff;
   logic [TW-1:0]    term_ff;
   logic [SW-1:0]    sum_ff;
   logic [NCW-1:0]   n_ff;
   logic [P1W-1:0]   p1_ff;
   logic [DW-1:0]    den_ff;

   logic                 rsp_valid_ff;
   logic [SUM_OUT_W-1:0] rsp_sum_ff;
   logic [CNT_OUT_W-1:0] rsp_cnt_ff;

   logic                 go_on;
   logic                 rsp_free;
   logic [P1W-1:0]       mul_a;
   logic [PRW-1:0]       prod;
   logic [PRW-1:0]       prod_sh;
   logic [NCW:0]         two_n;
   logic [DW-1:0]        den_w;
   logic [SW-1:0]        sum_next;
   logic [SUM_OUT_W-1:0] sum_sat;
   logic [CNT_OUT_W+NCW-1:0] cnt_ext;

   div_stat_type   div_stat;
   logic [P2W-1:0] div_q;

   assign go_on    = (term_ff >= TW'(thr_ff)) && (n_ff < NCW'(MAX_TERMS - 1));
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // shared multiplier: term * x first, then p1 * x
   assign mul_a   = (state_ff == ST_MUL1) ? P1W'(term_ff) : p1_ff;
   assign prod    = PRW'(mul_a) * PRW'(x_ff);
   assign prod_sh = prod >> X_FRAC_BITS;

   // divisor 4n^2 - 2n = 2n(2n - 1)
   assign two_n = {n_ff, 1'b0};
   assign den_w = DW'(two_n) * DW'(two_n - 1'b1);

   assign sum_next = sum_ff + SW'(term_ff);
   assign sum_sat  = (sum_ff > SW'(SUM_MAX)) ? SUM_MAX : sum_ff[SUM_OUT_W-1:0];
   assign cnt_ext  = {{CNT_OUT_W{1'b0}}, n_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = go_on ? ST_MUL1 : ST_FINISH;
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctl.load_item = req_chan.valid;
         end
         ST_CHECK: begin
            ctl.add_term = 1'b1;
         end
         ST_MUL1: begin
            ctl.load_p1 = 1'b1;
         end
         ST_MUL2: begin
            ctl.div_start = 1'b1;
         end
         ST_DIV_WAIT: begin
            ctl.load_term = div_stat.done;
         end
         ST_FINISH: begin
            ctl.load_rsp = rsp_free;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (ctl.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         x_ff    <= req_chan.x_value;
         term_ff <= TW'(1) << ONE_POS;
         sum_ff  <= '0;
         n_ff    <= '0;
      end
      if (ctl.add_term) begin
         sum_ff <= sum_next;
         n_ff   <= n_ff + 1'b1;
      end
      if (ctl.load_p1) begin
         p1_ff  <= prod_sh[P1W-1:0];
         den_ff <= den_w;
      end
      if (ctl.load_term) begin
         term_ff <= div_q[TW-1:0];
      end
      if (ctl.load_rsp) begin
         rsp_sum_ff <= sum_sat;
         rsp_cnt_ff <= cnt_ext[CNT_OUT_W-1:0];
      end
   end

   cts_div #(
      .NUM_W (P2W),
      .DEN_W (DW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (prod_sh[P2W-1:0]),
      .divisor  (den_ff),
      .stat     (div_stat),
      .quotient (div_q)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.series_sum = rsp_sum_ff;
   assign rsp_chan.term_count = rsp_cnt_ff;

   // the term count never runs past the cap while an item is worked
   `CTS_ASSERT(a_count_cap, clock, reset, (state_ff != ST_IDLE) |-> (n_ff <= NCW'(MAX_TERMS)))
   // the divider is only started when it is free
   `CTS_ASSERT(a_div_free, clock, reset, ctl.div_start |-> !div_stat.busy)
   // an accepted beat moves the sequencer straight to the first check
   `CTS_ASSERT(a_accept_check, clock, reset,
      (req_chan.valid && req_chan.ready) |=> (state_ff == ST_CHECK))
   // a result is only loaded when the output register can take it
   `CTS_ASSERT_ALWAYS(a_rsp_load, clock,
      ctl.load_rsp |-> (!rsp_valid_ff || rsp_chan.ready))

endmodule
`default_nettype wire
